// File: rtl/polar_unwrap_bilinear_sampler_assert.svh
// Assertion macros for the polar unwrap sampler.
`ifndef POLAR_UNWRAP_BILINEAR_SAMPLER_ASSERT_SVH
`define POLAR_UNWRAP_BILINEAR_SAMPLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PUBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pubs assertion failed");
`define PUBS_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("pubs assertion failed");
`else
`define PUBS_ASSERT_IMP(lbl, ante, cons)
`define PUBS_ASSERT_DLY(lbl, ante, dly, cons)
`endif
`endif

// File: rtl/pubs_pkg.sv
// Shared types, constants and the trig table builder for the polar unwrap sampler.
`default_nettype none
package pubs_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int ROM_FRAC   = 14;
  localparam int ROM_DEPTH  = 90;
  localparam int ROM_IDX_W  = 7;
  localparam int ROM_VAL_W  = 15;
  localparam int TRIG_W     = 16;
  localparam int ANGLE_W    = 9;
  localparam int RADIUS_W   = 10;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int PIX_W      = 8;
  localparam int WREG_W     = 11;
  localparam int HREG_W     = 10;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = 27;
  localparam int IDX_W      = 13;
  localparam int DIM_W      = 12;
  localparam int ANGLE_TURN = 360;
  localparam int ANGLE_QTR  = 90;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

  localparam logic [1:0] PATH_NEAR  = 2'd0;
  localparam logic [1:0] PATH_BILIN = 2'd1;
  localparam logic [1:0] PATH_CLAMP = 2'd2;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [ROW_W-1:0]    pixel_row;
    logic [COL_W-1:0]    pixel_col;
    logic [PIX_W-1:0]    pixel_value;
    logic [ANGLE_W-1:0]  angle_deg;
    logic [RADIUS_W-1:0] radius;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] sample;
    logic [1:0]       path;
  } out_t;

  typedef struct packed {
    logic valid;
    logic kind;
  } ctl_t;

  typedef logic [ROM_DEPTH-1:0][ROM_VAL_W-1:0] rom_t;

  function automatic int clog2_min1(input int v);
    return (v <= 2) ? 1 : $clog2(v);
  endfunction

  // Restoring division used only while the trig table is built at elaboration.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned dvs);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= dvs) begin
        r = r - dvs;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sine or cosine of whole degrees 0..89 in Q1.14, from a Q30 Taylor series.
  function automatic rom_t build_rom(input logic want_cos);
    rom_t tab;
    longint unsigned den, x, x2, ts, tc;
    longint s, c, v;
    int d, k;
    tab = '0;
    den = 64'd18000000;
    for (d = 0; d < ROM_DEPTH; d++) begin
      x = (64'(d) * 64'd314159) << 30;
      x = udiv64(x + (den >> 1), den);
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      s = longint'(ts);
      c = longint'(tc);
      for (k = 1; k <= 10; k++) begin
        ts = udiv64((ts * x2) >> 30, 64'(2 * k) * 64'(2 * k + 1));
        tc = udiv64((tc * x2) >> 30, 64'(2 * k - 1) * 64'(2 * k));
        if ((k & 1) == 1) begin
          s = s - longint'(ts);
          c = c - longint'(tc);
        end else begin
          s = s + longint'(ts);
          c = c + longint'(tc);
        end
      end
      v = want_cos ? c : s;
      if (v < 0) v = 0;
      tab[d] = ROM_VAL_W'((64'(v) + 64'd32768) >> 16);
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

// File: rtl/pubs_coord.sv
// Coordinate pipeline: angle reduction, trig lookup, products, fixed point and clamping.
`default_nettype none
module pubs_coord #(
  parameter int MAX_WIDTH  = pubs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pubs_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = pubs_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pubs_pkg::ctl_t                  ctl_i,
  input  pubs_pkg::in_t                   item_i,
  input  logic [pubs_pkg::COL_W-1:0]      center_col,
  input  logic [pubs_pkg::ROW_W-1:0]      center_row,
  input  logic [pubs_pkg::DIM_W-1:0]      wm1,
  input  logic [pubs_pkg::DIM_W-1:0]      hm1,
  output pubs_pkg::ctl_t                  ctl_o,
  output pubs_pkg::in_t                   item_o,
  output logic [pubs_pkg::clog2_min1(MAX_WIDTH)-1:0]  rx_o,
  output logic [pubs_pkg::clog2_min1(MAX_HEIGHT)-1:0] ry_o,
  output logic [FRAC_BITS-1:0]            fx_o,
  output logic [FRAC_BITS-1:0]            fy_o,
  output logic [1:0]                      path_o
);

  localparam int CW  = pubs_pkg::clog2_min1(MAX_WIDTH);
  localparam int RW  = pubs_pkg::clog2_min1(MAX_HEIGHT);
  localparam int XFW = pubs_pkg::IDX_W + FRAC_BITS;
  localparam int PW  = pubs_pkg::PROD_W;
  localparam pubs_pkg::rom_t SIN_TAB = pubs_pkg::build_rom(1'b0);
  localparam pubs_pkg::rom_t COS_TAB = pubs_pkg::build_rom(1'b1);

  pubs_pkg::ctl_t ctl_r [5];
  pubs_pkg::in_t  item_r [5];

  logic [pubs_pkg::ANGLE_W-1:0]   ang_red;
  logic [1:0]                     quad_nxt, quad_r;
  logic [pubs_pkg::ROM_IDX_W-1:0] deg_nxt, deg_r;
  logic signed [pubs_pkg::TRIG_W-1:0] sv, cv, sn_nxt, cs_nxt, sn_r, cs_r;
  logic signed [PW-1:0] px_r, py_r, x14, y14;
  logic signed [XFW-1:0] xf_r, yf_r, xlim, ylim;
  logic signed [pubs_pkg::IDX_W-1:0] x1, y1, wm1s, hm1s;
  logic [FRAC_BITS-1:0] fx, fy;
  logic bil;
  logic [CW-1:0] rx_nxt, rx_r;
  logic [RW-1:0] ry_nxt, ry_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r;
  logic [1:0] path_nxt, path_r;

  // Angle reduction and quadrant split.
  always_comb begin
    ang_red = (int'(item_i.angle_deg) >= pubs_pkg::ANGLE_TURN)
            ? item_i.angle_deg - pubs_pkg::ANGLE_W'(pubs_pkg::ANGLE_TURN) : item_i.angle_deg;
    if (int'(ang_red) < pubs_pkg::ANGLE_QTR) begin
      quad_nxt = 2'd0;
      deg_nxt  = pubs_pkg::ROM_IDX_W'(ang_red);
    end else if (int'(ang_red) < 2 * pubs_pkg::ANGLE_QTR) begin
      quad_nxt = 2'd1;
      deg_nxt  = pubs_pkg::ROM_IDX_W'(ang_red - pubs_pkg::ANGLE_W'(pubs_pkg::ANGLE_QTR));
    end else if (int'(ang_red) < 3 * pubs_pkg::ANGLE_QTR) begin
      quad_nxt = 2'd2;
      deg_nxt  = pubs_pkg::ROM_IDX_W'(ang_red - pubs_pkg::ANGLE_W'(2 * pubs_pkg::ANGLE_QTR));
    end else begin
      quad_nxt = 2'd3;
      deg_nxt  = pubs_pkg::ROM_IDX_W'(ang_red - pubs_pkg::ANGLE_W'(3 * pubs_pkg::ANGLE_QTR));
    end
  end

  // Quadrant symmetry applied to the first-quadrant table.
  always_comb begin
    sv = $signed({1'b0, SIN_TAB[deg_r]});
    cv = $signed({1'b0, COS_TAB[deg_r]});
    case (quad_r)
      2'd0: begin sn_nxt = sv;  cs_nxt = cv;  end
      2'd1: begin sn_nxt = cv;  cs_nxt = -sv; end
      2'd2: begin sn_nxt = -sv; cs_nxt = -cv; end
      default: begin sn_nxt = -cv; cs_nxt = sv; end
    endcase
  end

  always_comb begin
    x14 = $signed({(PW - pubs_pkg::COL_W - pubs_pkg::ROM_FRAC)'(0), center_col,
                   pubs_pkg::ROM_FRAC'(0)}) + px_r;
    y14 = $signed({(PW - pubs_pkg::ROW_W - pubs_pkg::ROM_FRAC)'(0), center_row,
                   pubs_pkg::ROM_FRAC'(0)}) - py_r;
  end

  // Split into integer and fraction, classify, and clamp the base pixel.
  always_comb begin
    x1   = xf_r[XFW-1:FRAC_BITS];
    y1   = yf_r[XFW-1:FRAC_BITS];
    fx   = xf_r[FRAC_BITS-1:0];
    fy   = yf_r[FRAC_BITS-1:0];
    wm1s = $signed({1'b0, wm1});
    hm1s = $signed({1'b0, hm1});
    xlim = $signed({1'b0, wm1, FRAC_BITS'(0)});
    ylim = $signed({1'b0, hm1, FRAC_BITS'(0)});
    bil  = (fx != '0) && (fy != '0) && (xf_r > 0) && (xf_r < xlim)
           && (yf_r > 0) && (yf_r < ylim);
    // The clamp below also gives the border rule, since floor and the compare agree.
    rx_nxt = x1[pubs_pkg::IDX_W-1] ? '0 : ((x1 > wm1s) ? CW'(wm1) : CW'(x1));
    ry_nxt = y1[pubs_pkg::IDX_W-1] ? '0 : ((y1 > hm1s) ? RW'(hm1) : RW'(y1));
    if (fx == '0 || fy == '0) path_nxt = pubs_pkg::PATH_NEAR;
    else if (bil)             path_nxt = pubs_pkg::PATH_BILIN;
    else                      path_nxt = pubs_pkg::PATH_CLAMP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) ctl_r[i] <= '0;
    end else begin
      ctl_r[0] <= ctl_i;
      for (int i = 1; i < 5; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    item_r[0] <= item_i;
    for (int i = 1; i < 5; i++) item_r[i] <= item_r[i-1];
    quad_r <= quad_nxt;
    deg_r  <= deg_nxt;
    sn_r   <= sn_nxt;
    cs_r   <= cs_nxt;
    px_r   <= $signed({1'b0, item_r[1].radius}) * cs_r;
    py_r   <= $signed({1'b0, item_r[1].radius}) * sn_r;
    xf_r   <= XFW'(x14 >>> (pubs_pkg::ROM_FRAC - FRAC_BITS));
    yf_r   <= XFW'(y14 >>> (pubs_pkg::ROM_FRAC - FRAC_BITS));
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    fx_r   <= (path_nxt == pubs_pkg::PATH_BILIN) ? fx : '0;
    fy_r   <= (path_nxt == pubs_pkg::PATH_BILIN) ? fy : '0;
    path_r <= path_nxt;
  end

  assign ctl_o  = ctl_r[4];
  assign item_o = item_r[4];
  assign rx_o   = rx_r;
  assign ry_o   = ry_r;
  assign fx_o   = fx_r;
  assign fy_o   = fy_r;
  assign path_o = path_r;

endmodule
`default_nettype wire

// File: rtl/pubs_store.sv
// Frame store split into four banks by row and column parity, one read each per cycle.
`default_nettype none
module pubs_store #(
  parameter int MAX_WIDTH  = pubs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pubs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  pubs_pkg::ctl_t             ctl_i,
  input  pubs_pkg::in_t              item_i,
  input  logic [pubs_pkg::clog2_min1(MAX_WIDTH)-1:0]  rx_i,
  input  logic [pubs_pkg::clog2_min1(MAX_HEIGHT)-1:0] ry_i,
  output logic [3:0][pubs_pkg::PIX_W-1:0] pix_o
);

  localparam int CW     = pubs_pkg::clog2_min1(MAX_WIDTH);
  localparam int RW     = pubs_pkg::clog2_min1(MAX_HEIGHT);
  localparam int COLS_H = (MAX_WIDTH + 1) / 2;
  localparam int ROWS_H = (MAX_HEIGHT + 1) / 2;
  localparam int DEPTH  = COLS_H * ROWS_H;
  localparam int AW     = pubs_pkg::clog2_min1(DEPTH);
  localparam int CHW    = pubs_pkg::clog2_min1(COLS_H) + 1;
  localparam int RHW    = pubs_pkg::clog2_min1(ROWS_H) + 1;

  logic [AW-1:0]  rd_addr [4];
  logic [AW-1:0]  wr_addr;
  logic [3:0]     wr_en;
  logic [CHW-1:0] ch;
  logic [RHW-1:0] rh;
  logic           wr_ok;

  // Each bank serves the one neighbor of the 2x2 window with its parity.
  always_comb begin
    ch = '0;
    rh = '0;
    for (int b = 0; b < 4; b++) begin
      ch = CHW'(rx_i >> 1) + CHW'(((b & 1) == 0) && rx_i[0]);
      rh = RHW'(ry_i >> 1) + RHW'(((b >> 1) == 0) && ry_i[0]);
      // A neighbor past the last row or column has zero weight; any address will do.
      if (int'(ch) >= COLS_H) ch = '0;
      if (int'(rh) >= ROWS_H) rh = '0;
      rd_addr[b] = AW'(int'(rh) * COLS_H + int'(ch));
    end
  end

  always_comb begin
    wr_ok   = ctl_i.valid && (ctl_i.kind == pubs_pkg::KIND_WRITE)
              && (int'(item_i.pixel_row) < MAX_HEIGHT) && (int'(item_i.pixel_col) < MAX_WIDTH);
    wr_addr = AW'(int'(item_i.pixel_row >> 1) * COLS_H + int'(item_i.pixel_col >> 1));
    for (int b = 0; b < 4; b++) begin
      wr_en[b] = wr_ok && (((b >> 1) & 1) == int'(item_i.pixel_row[0]))
                 && ((b & 1) == int'(item_i.pixel_col[0]));
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [pubs_pkg::PIX_W-1:0] mem [DEPTH];
    logic [pubs_pkg::PIX_W-1:0] q_r;
    always_ff @(posedge clk) begin
      if (wr_en[g]) mem[wr_addr] <= item_i.pixel_value;
      q_r <= mem[rd_addr[g]];
    end
    assign pix_o[g] = q_r;
  end

endmodule
`default_nettype wire

// File: rtl/pubs_blend.sv
// Bilinear blend: corner weights, weighted pixels, then the truncated sum.
`default_nettype none
module pubs_blend #(
  parameter int FRAC_BITS = pubs_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            valid_i,
  input  logic [1:0]                      path_i,
  input  logic [FRAC_BITS-1:0]            fx_i,
  input  logic [FRAC_BITS-1:0]            fy_i,
  input  logic                            rx0_i,
  input  logic                            ry0_i,
  input  logic [3:0][pubs_pkg::PIX_W-1:0] pix_i,
  output logic                            out_valid,
  output pubs_pkg::out_t                  out_data
);

  localparam int WW = 2 * FRAC_BITS + 1;
  localparam int PW = WW + pubs_pkg::PIX_W;
  localparam int SW = PW + 2;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, FRAC_BITS'(0)};

  logic [FRAC_BITS:0]   wx [2];
  logic [FRAC_BITS:0]   wy [2];
  logic [WW-1:0]        wt [4];
  logic [WW-1:0]        w_r [4];
  logic [pubs_pkg::PIX_W-1:0] p_r [4];
  logic [PW-1:0]        prod_r [4];
  logic [SW-1:0]        sum;
  logic                 v1_r, v2_r, out_valid_r;
  logic [1:0]           path1_r, path2_r;
  pubs_pkg::out_t       out_r;

  always_comb begin
    wx[0] = ONE - {1'b0, fx_i};
    wx[1] = {1'b0, fx_i};
    wy[0] = ONE - {1'b0, fy_i};
    wy[1] = {1'b0, fy_i};
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        wt[dy*2+dx] = WW'(wy[dy]) * WW'(wx[dx]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        w_r[dy*2+dx] <= wt[dy*2+dx];
        p_r[dy*2+dx] <= pix_i[{ry0_i ^ dy[0], rx0_i ^ dx[0]}];
      end
    end
    // Zero-weight corners may come from pixels never written, so they are forced out.
    for (int i = 0; i < 4; i++) prod_r[i] <= (w_r[i] == '0) ? '0 : w_r[i] * p_r[i];
    out_r.sample <= sum[2*FRAC_BITS +: pubs_pkg::PIX_W];
    out_r.path   <= path2_r;
    path1_r <= path_i;
    path2_r <= path1_r;
  end

  always_comb begin
    sum = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]) + SW'(prod_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= valid_i;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: rtl/polar_unwrap_bilinear_sampler.sv
// A sample request goes through the input register, coordinate pipeline, store and blend.
// Throughput: one transaction per cycle, pixel write or sample request; busy stays low.
// The rate is set by the four-bank frame store, which reads one pixel per bank per cycle.
// Reset clears the pipeline valid bits and the centre registers; sizes reset to 640x480.
// The frame store is not cleared; only pixels already written are meaningful.
`default_nettype none
`include "polar_unwrap_bilinear_sampler_assert.svh"
module polar_unwrap_bilinear_sampler #(
  parameter int MAX_WIDTH  = pubs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pubs_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = pubs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  pubs_pkg::in_t                     in_data,
  output logic                              out_valid,
  output pubs_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [pubs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pubs_pkg::CFG_W-1:0]        cfg_data
);

  localparam int CW = pubs_pkg::clog2_min1(MAX_WIDTH);
  localparam int RW = pubs_pkg::clog2_min1(MAX_HEIGHT);

  logic [pubs_pkg::COL_W-1:0]  center_col_r;
  logic [pubs_pkg::ROW_W-1:0]  center_row_r;
  logic [pubs_pkg::WREG_W-1:0] image_width_r;
  logic [pubs_pkg::HREG_W-1:0] image_height_r;
  logic [pubs_pkg::DIM_W-1:0]  wm1_nxt, wm1_r, hm1_nxt, hm1_r;

  pubs_pkg::ctl_t in_ctl_nxt, in_ctl_r, co_ctl;
  pubs_pkg::in_t  in_item_r, co_item;
  logic [CW-1:0]  co_rx;
  logic [RW-1:0]  co_ry;
  logic [FRAC_BITS-1:0] co_fx, co_fy, st_fx_r, st_fy_r;
  logic [1:0]     co_path, st_path_r;
  logic           st_vld_r, st_rx0_r, st_ry0_r;
  logic [3:0][pubs_pkg::PIX_W-1:0] st_pix;

  // Every cycle can take a transaction.
  assign busy = 1'b0;

  assign in_ctl_nxt = '{valid: start && !busy, kind: in_data.kind};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_col_r   <= '0;
      center_row_r   <= '0;
      image_width_r  <= pubs_pkg::WREG_W'(640);
      image_height_r <= pubs_pkg::HREG_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        pubs_pkg::CFG_CENTER_COL:   center_col_r   <= cfg_data[pubs_pkg::COL_W-1:0];
        pubs_pkg::CFG_CENTER_ROW:   center_row_r   <= cfg_data[pubs_pkg::ROW_W-1:0];
        pubs_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[pubs_pkg::WREG_W-1:0];
        pubs_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[pubs_pkg::HREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Last usable column and row, with the size registers forced into range.
  always_comb begin
    if (int'(image_width_r) < 2)              wm1_nxt = pubs_pkg::DIM_W'(1);
    else if (int'(image_width_r) > MAX_WIDTH) wm1_nxt = pubs_pkg::DIM_W'(MAX_WIDTH - 1);
    else wm1_nxt = pubs_pkg::DIM_W'(image_width_r) - pubs_pkg::DIM_W'(1);
    if (int'(image_height_r) < 2)               hm1_nxt = pubs_pkg::DIM_W'(1);
    else if (int'(image_height_r) > MAX_HEIGHT) hm1_nxt = pubs_pkg::DIM_W'(MAX_HEIGHT - 1);
    else hm1_nxt = pubs_pkg::DIM_W'(image_height_r) - pubs_pkg::DIM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ctl_r <= '0;
      st_vld_r <= 1'b0;
    end else begin
      in_ctl_r <= in_ctl_nxt;
      st_vld_r <= co_ctl.valid && (co_ctl.kind == pubs_pkg::KIND_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_data;
    wm1_r     <= wm1_nxt;
    hm1_r     <= hm1_nxt;
    st_path_r <= co_path;
    st_fx_r   <= co_fx;
    st_fy_r   <= co_fy;
    st_rx0_r  <= co_rx[0];
    st_ry0_r  <= co_ry[0];
  end

  pubs_coord #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)
  ) u_coord (
    .clk(clk), .rst_n(rst_n), .ctl_i(in_ctl_r), .item_i(in_item_r),
    .center_col(center_col_r), .center_row(center_row_r), .wm1(wm1_r), .hm1(hm1_r),
    .ctl_o(co_ctl), .item_o(co_item), .rx_o(co_rx), .ry_o(co_ry),
    .fx_o(co_fx), .fy_o(co_fy), .path_o(co_path)
  );

  pubs_store #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)
  ) u_store (
    .clk(clk), .ctl_i(co_ctl), .item_i(co_item), .rx_i(co_rx), .ry_i(co_ry), .pix_o(st_pix)
  );

  pubs_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk(clk), .rst_n(rst_n), .valid_i(st_vld_r), .path_i(st_path_r),
    .fx_i(st_fx_r), .fy_i(st_fy_r), .rx0_i(st_rx0_r), .ry0_i(st_ry0_r), .pix_i(st_pix),
    .out_valid(out_valid), .out_data(out_data)
  );

  `PUBS_ASSERT_IMP(a_strobe_has_request, out_valid, $past(start && in_data.kind, 10))
  `PUBS_ASSERT_DLY(a_request_gives_strobe, start && in_data.kind, 10, out_valid)
  `PUBS_ASSERT_DLY(a_write_gives_none, start && !in_data.kind, 10, !out_valid)

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the polar unwrap bilinear sampler.
module testbench;

  localparam int FRAME_W = 1024;
  localparam int FRAME_H = 512;
  localparam int STALL_LIMIT = 3000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  pubs_pkg::in_t in_data;
  logic out_valid;
  pubs_pkg::out_t out_data;
  logic cfg_we;
  logic [pubs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pubs_pkg::CFG_W-1:0] cfg_data;

  polar_unwrap_bilinear_sampler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the block's frame and registers.
  logic [7:0] frame_px [0:FRAME_W*FRAME_H-1];
  bit frame_set [0:FRAME_W*FRAME_H-1];
  longint sin_tab [0:89];
  longint cos_tab [0:89];
  logic [9:0] org_col;
  logic [8:0] org_row;
  logic [10:0] width_reg;
  logic [9:0] height_reg;

  pubs_pkg::out_t expected_samples[$];
  int fail_count;
  int stall_cycles;
  bit no_gaps;

  function automatic longint to_q14(input longint v);
    if (v < 0) v = 0;
    return (v + 32768) >>> 16;
  endfunction

  // Trig table: Taylor series in Q30, rounded to Q1.14.
  function automatic void fill_trig_tables();
    longint unsigned den, x, x2, ts, tc;
    longint s, c;
    den = 64'd18000000;
    for (int d = 0; d < 90; d++) begin
      x = (64'(d) * 64'd314159) << 30;
      x = (x + den / 2) / den;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      s = longint'(ts);
      c = longint'(tc);
      for (int k = 1; k <= 10; k++) begin
        ts = ((ts * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
        tc = ((tc * x2) >> 30) / (64'(2 * k - 1) * 64'(2 * k));
        if (k % 2 == 1) begin
          s -= longint'(ts);
          c -= longint'(tc);
        end else begin
          s += longint'(ts);
          c += longint'(tc);
        end
      end
      sin_tab[d] = to_q14(s);
      cos_tab[d] = to_q14(c);
    end
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Computes the grey level at a polar point and lists the frame addresses it reads.
  function automatic void predict_sample(input logic [8:0] ang, input logic [9:0] rad,
                                         output pubs_pkg::out_t res, output int nrd,
                                         output int addr [4]);
    int a, q, d;
    longint sn, cs, x14, y14, xf, yf, x1, y1, fx, fy, w, h, cx, cy, acc;
    a = int'(ang) % 360;
    q = a / 90;
    d = a % 90;
    case (q)
      0: begin sn = sin_tab[d]; cs = cos_tab[d]; end
      1: begin sn = cos_tab[d]; cs = -sin_tab[d]; end
      2: begin sn = -sin_tab[d]; cs = -cos_tab[d]; end
      default: begin sn = -cos_tab[d]; cs = sin_tab[d]; end
    endcase
    x14 = longint'(org_col) * 16384 + longint'(rad) * cs;
    y14 = longint'(org_row) * 16384 - longint'(rad) * sn;
    xf = x14 >>> 6;
    yf = y14 >>> 6;
    w = clip(longint'(width_reg), 2, FRAME_W);
    h = clip(longint'(height_reg), 2, FRAME_H);
    x1 = xf >>> 8;
    y1 = yf >>> 8;
    fx = xf - x1 * 256;
    fy = yf - y1 * 256;
    addr = '{0, 0, 0, 0};
    if (fx == 0 || fy == 0) begin
      res.path = pubs_pkg::PATH_NEAR;
      nrd = 1;
      addr[0] = int'(clip(y1, 0, h - 1) * FRAME_W + clip(x1, 0, w - 1));
      res.sample = frame_px[addr[0]];
    end else if (xf > 0 && xf < (w - 1) * 256 && yf > 0 && yf < (h - 1) * 256) begin
      res.path = pubs_pkg::PATH_BILIN;
      nrd = 4;
      addr[0] = int'(y1 * FRAME_W + x1);
      addr[1] = addr[0] + 1;
      addr[2] = addr[0] + FRAME_W;
      addr[3] = addr[2] + 1;
      acc = (256 - fx) * (256 - fy) * frame_px[addr[0]] + fx * (256 - fy) * frame_px[addr[1]]
          + (256 - fx) * fy * frame_px[addr[2]] + fx * fy * frame_px[addr[3]];
      res.sample = 8'(acc >> 16);
    end else begin
      res.path = pubs_pkg::PATH_CLAMP;
      nrd = 1;
      cx = xf <= 0 ? 0 : (xf >= (w - 1) * 256 ? w - 1 : x1);
      cy = yf <= 0 ? 0 : (yf >= (h - 1) * 256 ? h - 1 : y1);
      addr[0] = int'(cy * FRAME_W + cx);
      res.sample = frame_px[addr[0]];
    end
  endfunction

  task automatic pause_cycles(input int n);
    repeat (n) @(posedge clk);
  endtask

  // Holds start high until the item is taken; start stays high for a following item.
  task automatic send_item(input pubs_pkg::in_t item);
    pubs_pkg::out_t res;
    int nrd;
    int addr [4];
    start <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (item.kind == pubs_pkg::KIND_WRITE) begin
      frame_px[int'(item.pixel_row) * FRAME_W + int'(item.pixel_col)] = item.pixel_value;
      frame_set[int'(item.pixel_row) * FRAME_W + int'(item.pixel_col)] = 1'b1;
    end else begin
      predict_sample(item.angle_deg, item.radius, res, nrd, addr);
      expected_samples.insert(expected_samples.size(), res);
    end
  endtask

  task automatic random_gap();
    int roll, len;
    roll = $urandom_range(0, 19);
    if (no_gaps || roll < 12) return;
    len = roll < 18 ? $urandom_range(1, 3) : $urandom_range(10, 40);
    start <= 1'b0;
    pause_cycles(len);
  endtask

  function automatic pubs_pkg::in_t random_fields();
    pubs_pkg::in_t item;
    item.kind = 1'($urandom);
    item.pixel_row = 9'($urandom);
    item.pixel_col = 10'($urandom);
    item.pixel_value = 8'($urandom);
    item.angle_deg = 9'($urandom);
    item.radius = 10'($urandom);
    return item;
  endfunction

  // Writes any pixel the request would read that has never been written, then sends it.
  task automatic request_sample(input logic [8:0] ang, input logic [9:0] rad);
    pubs_pkg::in_t item;
    pubs_pkg::out_t res;
    int nrd;
    int addr [4];
    predict_sample(ang, rad, res, nrd, addr);
    for (int i = 0; i < nrd; i++) begin
      if (!frame_set[addr[i]]) begin
        item = random_fields();
        item.kind = pubs_pkg::KIND_WRITE;
        item.pixel_row = 9'(addr[i] / FRAME_W);
        item.pixel_col = 10'(addr[i] % FRAME_W);
        send_item(item);
        random_gap();
      end
    end
    item = random_fields();
    item.kind = pubs_pkg::KIND_SAMPLE;
    item.angle_deg = ang;
    item.radius = rad;
    send_item(item);
    random_gap();
  endtask

  task automatic write_pixel(input int row, input int col, input logic [7:0] value);
    pubs_pkg::in_t item;
    item = random_fields();
    item.kind = pubs_pkg::KIND_WRITE;
    item.pixel_row = 9'(row);
    item.pixel_col = 10'(col);
    item.pixel_value = value;
    send_item(item);
    random_gap();
  endtask

  // Lets the pipeline drain so that register writes land while the block is idle.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    pause_cycles(14);
  endtask

  task automatic write_reg(input logic [pubs_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= pubs_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pubs_pkg::CFG_CENTER_COL: org_col = 10'(value);
      pubs_pkg::CFG_CENTER_ROW: org_row = 9'(value);
      pubs_pkg::CFG_IMAGE_WIDTH: width_reg = 11'(value);
      default: height_reg = 10'(value);
    endcase
  endtask

  task automatic set_geometry(input int ccol, input int crow, input int w, input int h);
    wait_drained();
    write_reg(pubs_pkg::CFG_CENTER_COL, ccol);
    write_reg(pubs_pkg::CFG_CENTER_ROW, crow);
    write_reg(pubs_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(pubs_pkg::CFG_IMAGE_HEIGHT, h);
  endtask

  // Reset geometry: origin at the top left corner, so most points clamp or land on row 0.
  task automatic test_reset_geometry();
    request_sample(9'd0, 10'd0);
    request_sample(9'd0, 10'd1023);
    request_sample(9'd270, 10'd100);
    request_sample(9'd315, 10'd50);
    request_sample(9'd135, 10'd7);
  endtask

  task automatic test_paths_and_angles();
    set_geometry(20, 15, 40, 30);
    request_sample(9'd0, 10'd5);
    request_sample(9'd90, 10'd5);
    request_sample(9'd180, 10'd5);
    request_sample(9'd270, 10'd5);
    request_sample(9'd359, 10'd10);
    request_sample(9'd360, 10'd10);
    request_sample(9'd511, 10'd10);
    request_sample(9'd30, 10'd7);
    request_sample(9'd200, 10'd13);
    // Points in the band between the last column and the width, and past every edge.
    request_sample(9'd1, 10'd19);
    request_sample(9'd179, 10'd25);
    request_sample(9'd91, 10'd16);
    request_sample(9'd269, 10'd15);
    request_sample(9'd45, 10'd1023);
    write_pixel(511, 1023, 8'hff);
    write_pixel(0, 0, 8'h00);
  endtask

  // Size registers outside the legal range are clamped by the block.
  task automatic test_size_clamp();
    set_geometry(1023, 511, 0, 1023);
    request_sample(9'd0, 10'd0);
    request_sample(9'd225, 10'd3);
    request_sample(9'd180, 10'd600);
    set_geometry(0, 0, 2047, 1);
    request_sample(9'd300, 10'd1);
    request_sample(9'd315, 10'd2);
  endtask

  task automatic random_phase(input int count);
    pubs_pkg::in_t item;
    int roll;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 9);
      item = random_fields();
      if (roll < 2) begin
        // Requests always go through request_sample so every pixel read has been written.
        item.kind = pubs_pkg::KIND_WRITE;
        send_item(item);
        random_gap();
      end else if (roll < 8) begin
        request_sample(item.angle_deg, 10'($urandom_range(0, 120)));
      end else begin
        request_sample(item.angle_deg, item.radius);
      end
    end
  endtask

  task automatic test_random_geometries();
    set_geometry(320, 240, 640, 480);
    random_phase(40);
    set_geometry(1, 1, 3, 3);
    random_phase(40);
    set_geometry($urandom_range(0, 1023), $urandom_range(0, 511), 1024, 512);
    random_phase(40);
    set_geometry(60, 40, 2, 2);
    random_phase(20);
    set_geometry($urandom_range(0, 1023), $urandom_range(0, 511),
                 $urandom_range(0, 2047), $urandom_range(0, 1023));
    random_phase(40);
    set_geometry(512, 256, $urandom_range(2, 1024), $urandom_range(2, 512));
    random_phase(40);
  endtask

  always @(posedge clk) begin
    pubs_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected result: sample %0d path %0d", out_data.sample, out_data.path);
        fail_count++;
      end else begin
        want = expected_samples.pop_front();
        if (out_data.sample !== want.sample) begin
          $error("sample: expected %0d actual %0d", want.sample, out_data.sample);
          fail_count++;
        end
        if (out_data.path !== want.path) begin
          $error("path: expected %0d actual %0d", want.path, out_data.path);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transaction moves in either direction.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    fail_count = 0;
    no_gaps = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    org_col = '0;
    org_row = '0;
    width_reg = 11'd640;
    height_reg = 10'd480;
    for (int i = 0; i < FRAME_W * FRAME_H; i++) begin
      frame_px[i] = 8'h00;
      frame_set[i] = 1'b0;
    end
    fill_trig_tables();
    pause_cycles(7);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_geometry();
    test_paths_and_angles();
    test_size_clamp();
    test_random_geometries();
    wait_drained();
    pause_cycles(10);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/pubs_pkg.sv
rtl/pubs_coord.sv
rtl/pubs_store.sv
rtl/pubs_blend.sv
rtl/polar_unwrap_bilinear_sampler.sv
verif/testbench.sv
